FILE: rtl/pam_pkg.sv
`timescale 1ns / 1ps
// pam_pkg: shared types and constants for the peak acceleration magnitude unit
// controller state, command and status structs, fixed widths and scale constants
// no dependencies

package pam_pkg;

    localparam int AXIS_W    = 16;
    localparam int MAG_W     = 14;
    localparam int SUM_W     = 29;
    localparam int RAD_W     = 30;
    localparam int ROOT_W    = 15;
    localparam int REM_W     = 18;
    localparam int PROD_W    = 25;
    localparam int OUT_W     = 16;
    localparam int CNT_W     = 4;

    localparam logic [AXIS_W-1:0] AXIS_LIMIT  = 16'd10000;
    localparam logic [9:0]        MILLI_SCALE = 10'd1000;
    localparam logic [3:0]        FULL_SHIFT  = 4'd10;
    localparam logic [CNT_W-1:0]  SQ_LAST     = 4'd2;
    localparam logic [CNT_W-1:0]  ROOT_LAST   = 4'd14;

    localparam logic [1:0]        RANGE_RESET = 2'd3;
    localparam logic              REG_IDX_RANGE_CODE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT_LOAD,
        ST_SQRT,
        ST_UPDATE,
        ST_SCALE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       root_load;
        logic       root_step;
        logic       update;
        logic       scale;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/peak_accel_magnitude_unit.sv
`timescale 1ns / 1ps
// peak_accel_magnitude_unit: top level, stream ports, register port and the two sub-blocks
// depends on pam_pkg, pam_ctrl and pam_dp

// Takes one three-axis frame per transfer and reports, on the frame flagged by tlast, the
// largest valid magnitude of the batch in milli-g, saturated at 65535, then clears the peak.
// A frame is skipped when all axes are zero or any axis exceeds 10000 counts. Frames are
// handled one at a time, from transfer to ready again: accept, the three squares through
// the shared squaring multiplier, one load and fifteen steps of the bit-pair square root,
// one peak update; a final frame then also passes scaling and output load, and waits while
// an unread earlier result holds the output register.
// range_code lives at byte address 0 of the register port, reset value 3 (16g).

module peak_accel_magnitude_unit
    import pam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // axis_x [15:0], axis_y [31:16], axis_z [47:32]
    input  logic        s_tlast,    // final_frame

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // peak_milli_g [15:0]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t       cmd;
    status_t    sts;
    logic [1:0] range_code_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            range_code_reg <= RANGE_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_RANGE_CODE))
            range_code_reg <= pwdata[1:0];
    end

    assign prdata = (paddr[2] == REG_IDX_RANGE_CODE) ? {30'd0, range_code_reg} : 32'd0;

    pam_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pam_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .range_code (range_code_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: rtl/pam_ctrl.sv
`timescale 1ns / 1ps
// pam_ctrl: sequencing state machine for the peak acceleration magnitude unit
// issues datapath commands; depends on pam_pkg

module pam_ctrl
    import pam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                cmd.sq_sel  = cnt_reg[1:0];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_ROOT_LOAD;
                end
            end
            ST_ROOT_LOAD:
            begin
                cmd.root_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (sts.last)
                    state_next = ST_SCALE;
                else
                    state_next = ST_IDLE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register loaded while occupied");

    a_load_to_sq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_SQ && cnt_reg == '0))
        else $error("accepted frame did not start squaring");

    a_root_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> (cnt_reg <= ROOT_LAST))
        else $error("root step count overran");

    a_update_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> $past(cmd.root_step))
        else $error("peak update without a finished root");
`endif

endmodule

FILE: rtl/pam_dp.sv
`timescale 1ns / 1ps
// pam_dp: datapath for the peak acceleration magnitude unit
// frame check, squares, iterative root, running peak, scaling and output register; uses pam_pkg

module pam_dp
    import pam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           sts,
    input  logic [47:0]       s_tdata,
    input  logic              s_tlast,
    input  logic [1:0]        range_code,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [OUT_W-1:0]  m_tdata
);

    logic signed [AXIS_W-1:0] ax, ay, az;
    logic [AXIS_W-1:0]        mx, my, mz;
    logic                     all_zero, too_big;

    logic [MAG_W-1:0]   mag_x_reg, mag_y_reg, mag_z_reg;
    logic               valid_reg;
    logic               last_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [ROOT_W-1:0]  peak_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic [MAG_W-1:0]   sq_op;
    logic [SUM_W-1:0]   sq_val;
    logic [REM_W+1:0]   cand, trial;
    logic               take;
    logic [3:0]         shift_amt;
    logic [PROD_W-1:0]  shifted;
    logic [OUT_W-1:0]   sat_val;

    assign ax = s_tdata[15:0];
    assign ay = s_tdata[31:16];
    assign az = s_tdata[47:32];

    // magnitude; the most negative code maps to 32768
    assign mx = ax[AXIS_W-1] ? AXIS_W'(-ax) : AXIS_W'(ax);
    assign my = ay[AXIS_W-1] ? AXIS_W'(-ay) : AXIS_W'(ay);
    assign mz = az[AXIS_W-1] ? AXIS_W'(-az) : AXIS_W'(az);

    assign all_zero = (mx == '0) && (my == '0) && (mz == '0);
    assign too_big  = (mx > AXIS_LIMIT) || (my > AXIS_LIMIT) || (mz > AXIS_LIMIT);

    always_comb
    begin
        unique case (cmd.sq_sel)
            2'd0:    sq_op = mag_x_reg;
            2'd1:    sq_op = mag_y_reg;
            default: sq_op = mag_z_reg;
        endcase
    end

    assign sq_val = SUM_W'(sq_op) * SUM_W'(sq_op);

    // one radicand digit pair per step
    assign cand  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_reg, 2'b01});
    assign take  = (cand >= trial);

    assign shift_amt = FULL_SHIFT - {2'b00, range_code};
    assign shifted   = prod_reg >> shift_amt;
    assign sat_val   = (shifted > PROD_W'(16'hFFFF)) ? 16'hFFFF : shifted[OUT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_x_reg <= mx[MAG_W-1:0];
            mag_y_reg <= my[MAG_W-1:0];
            mag_z_reg <= mz[MAG_W-1:0];
            valid_reg <= !all_zero && !too_big;
            last_reg  <= s_tlast;
            acc_reg   <= '0;
        end
        else if (cmd.sq_step)
        begin
            acc_reg <= acc_reg + sq_val;
        end

        if (cmd.root_load)
        begin
            rad_reg  <= {1'b0, acc_reg};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? REM_W'(cand - trial) : cand[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end

        if (cmd.scale)
            prod_reg <= PROD_W'(peak_reg) * PROD_W'(MILLI_SCALE);

        if (cmd.out_load)
            out_data_reg <= sat_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update && valid_reg && (root_reg > peak_reg))
                peak_reg <= root_reg;
            else if (cmd.scale)
                peak_reg <= '0;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

endmodule

FILE: verif/tb_peak_accel_magnitude_unit.sv
`timescale 1ns / 1ps
// tb_peak_accel_magnitude_unit: self-checking bench for the peak acceleration magnitude unit
// drives frame transfers and register writes, predicts each batch peak and checks the stream out
// depends on peak_accel_magnitude_unit

module tb_peak_accel_magnitude_unit;

    localparam int          HALF_PERIOD = 4;
    localparam int          AXIS_MAX    = 10000;
    localparam int          MILLI       = 1000;
    localparam int          BASE_SHIFT  = 10;
    localparam int          PEAK_SAT    = 65535;
    localparam int          SETTLE      = 40;
    localparam int          HOLD_CYCLES = 500;
    localparam int          IDLE_PCT    = 36;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [2:0]  ADDR_RANGE  = 3'd0;
    localparam logic [2:0]  ADDR_SPARE  = 3'd4;
    localparam int          DIR_ROWS    = 20;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
        logic               typed;
        logic [15:0]        val;
    } frame_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;     // axis_x [15:0], axis_y [31:16], axis_z [47:32]
    logic        s_tlast;     // final_frame
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // peak_milli_g [15:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [14:0] peak_now;
    logic [1:0]  range_now;
    frame_t      frame_notes[$];
    logic [15:0] peak_q[$];
    int          errors;
    int          cycles;
    bit          no_idle;
    bit          hold_req;

    // range 3 after reset, so the scale is a right shift by 7
    frame_t dir_rows [0:DIR_ROWS-1] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b1, 16'd0},
        '{16'sd10000,  16'sd10000,  16'sd10000,  1'b1, 1'b1, 16'd65535},
        '{-16'sd10000, -16'sd10000, -16'sd10000, 1'b1, 1'b1, 16'd65535},
        '{-16'sd10000, 16'sd0,      16'sd0,      1'b1, 1'b1, 16'd65535},
        '{16'h8000,    16'sd0,      16'sd0,      1'b1, 1'b1, 16'd0},
        '{16'sd0,      16'sd32767,  16'sd0,      1'b1, 1'b1, 16'd0},
        '{16'sd0,      16'sd0,      16'sd10001,  1'b1, 1'b1, 16'd0},
        '{16'sd0,      16'sd0,      16'sd1,      1'b1, 1'b1, 16'd7},
        '{-16'sd1,     -16'sd1,     -16'sd1,     1'b1, 1'b1, 16'd7},
        '{16'sd1,      16'sd1,      16'sd1,      1'b0, 1'b0, 16'd0},
        '{16'sd3,      16'sd4,      16'sd0,      1'b0, 1'b0, 16'd0},
        '{16'h8000,    16'sd5,      16'sd5,      1'b1, 1'b1, 16'd39},
        '{16'sd100,    -16'sd200,   16'sd300,    1'b0, 1'b0, 16'd0},
        '{16'sd0,      16'sd0,      16'sd0,      1'b0, 1'b0, 16'd0},
        '{16'sd9999,   -16'sd9999,  16'sd1,      1'b0, 1'b0, 16'd0},
        '{-16'sd1,     16'sd0,      -16'sd10001, 1'b1, 1'b0, 16'd0},
        '{-16'sd6,     16'sd8,      16'sd0,      1'b0, 1'b0, 16'd0},
        '{16'sd10001,  16'sd10001,  16'sd10001,  1'b0, 1'b0, 16'd0},
        '{16'sd2,      -16'sd3,     16'sd6,      1'b1, 1'b0, 16'd0},
        '{16'h5555,    16'haaaa,    16'h7fff,    1'b1, 1'b1, 16'd0}
    };

    peak_accel_magnitude_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic fold_frame(input frame_t f, output bit emit, output logic [15:0] res);
        int              ax;
        int              ay;
        int              az;
        longint unsigned sum;
        longint unsigned root;
        longint unsigned cand;
        longint unsigned prod;
        ax = (f.x < 0) ? -int'(f.x) : int'(f.x);
        ay = (f.y < 0) ? -int'(f.y) : int'(f.y);
        az = (f.z < 0) ? -int'(f.z) : int'(f.z);
        if (!(ax == 0 && ay == 0 && az == 0) && ax <= AXIS_MAX && ay <= AXIS_MAX
            && az <= AXIS_MAX)
        begin
            sum  = ax * ax + ay * ay + az * az;
            root = 0;
            for (int b = 14; b >= 0; b--)
            begin
                cand = root | (64'd1 << b);
                if (cand * cand <= sum)
                    root = cand;
            end
            if (root > peak_now)
                peak_now = root[14:0];
        end
        emit = f.last;
        res  = '0;
        if (f.last)
        begin
            prod = (longint'(peak_now) * MILLI) >> (BASE_SHIFT - range_now);
            res  = (prod > PEAK_SAT) ? 16'hffff : prod[15:0];
            peak_now = '0;
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RANGE)
            range_now = data[1:0];
    endtask

    task automatic apb_check_range;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_RANGE;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {30'd0, range_now})
            report_mismatch("range_code readback", prdata, {30'd0, range_now});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_frame(input frame_t f);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
        frame_notes.push_back(f);
        s_tvalid <= 1'b1;
        s_tdata  <= {f.z, f.y, f.x};
        s_tlast  <= f.last;
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
    endtask

    function automatic logic signed [15:0] pick_axis(input bit in_range);
        int sel;
        sel = $urandom_range(0, 99);
        if (in_range)
        begin
            if (sel < 20)
                return 16'(int'($urandom_range(0, 40)) - 20);
            return 16'(int'($urandom_range(0, 2 * AXIS_MAX)) - AXIS_MAX);
        end
        if (sel < 60)
            return 16'($urandom);
        case ($urandom_range(0, 6))
            0: return 16'sd10000;
            1: return -16'sd10000;
            2: return 16'sd10001;
            3: return -16'sd10001;
            4: return 16'h8000;
            5: return 16'sd32767;
            default: return 16'sd0;
        endcase
    endfunction

    task automatic run_batches(input int n_items, input bit short_runs);
        int     sent;
        int     len;
        bit     clean;
        frame_t f;
        sent = 0;
        while (sent < n_items)
        begin
            len = short_runs ? $urandom_range(1, 3) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                clean   = $urandom_range(0, 99) < 75;
                f.x     = pick_axis(clean);
                f.y     = pick_axis(clean);
                f.z     = pick_axis(clean);
                f.last  = (i == len - 1);
                f.typed = 1'b0;
                f.val   = '0;
                send_frame(f);
                sent++;
            end
        end
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (peak_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : scoreboard
        frame_t      note;
        bit          emit;
        logic [15:0] predicted;
        logic [15:0] want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                note = frame_notes.pop_front();
                fold_frame(note, emit, predicted);
                if (emit)
                    peak_q.push_back(note.typed ? note.val : predicted);
            end
            if (m_tvalid && m_tready)
            begin
                if (peak_q.size() == 0)
                    report_mismatch("unexpected peak_milli_g", m_tdata, 0);
                else
                begin
                    want = peak_q.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("peak_milli_g", m_tdata, want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // output side back-pressure, with one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rst_n)
                m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        peak_now  = '0;
        range_now = 2'd3;
        errors    = 0;
        cycles    = 0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        apb_check_range();
        for (int i = 0; i < DIR_ROWS; i++)
            send_frame(dir_rows[i]);
        wait_drained();

        apb_write(ADDR_RANGE, 32'd0);
        apb_check_range();
        run_batches(150, 1'b0);
        wait_drained();

        // upper bits dropped, spare address ignored, no idling in this phase
        apb_write(ADDR_RANGE, 32'hffff_fff9);
        apb_write(ADDR_SPARE, 32'd2);
        apb_check_range();
        no_idle = 1'b1;
        run_batches(150, 1'b0);
        wait_drained();
        no_idle = 1'b0;

        apb_write(ADDR_RANGE, 32'd2);
        apb_check_range();
        hold_req = 1'b1;
        run_batches(60, 1'b1);
        run_batches(90, 1'b0);
        wait_drained();

        apb_write(ADDR_RANGE, 32'd3);
        apb_check_range();
        run_batches(150, 1'b0);
        wait_drained();

        apb_write(ADDR_RANGE, 32'd0);
        apb_check_range();
        run_batches(150, 1'b0);
        wait_drained();

        if (errors == 0 && peak_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pam_pkg.sv
rtl/pam_ctrl.sv
rtl/pam_dp.sv
rtl/peak_accel_magnitude_unit.sv
verif/tb_peak_accel_magnitude_unit.sv
